// ===== design/binary_to_decimal_ascii_macros.svh =====
// Assertion helpers for the binary to decimal converter.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bda_pkg.sv =====
package bda_pkg;

	localparam int unsigned DEFAULT_VALUE_BITS = 32;
	localparam int unsigned INPUT_BITS = 32;
	localparam int unsigned CHAR_BITS = 6;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Queue status seen by both sides.
	typedef struct packed {
		logic empty;
		logic full;
	} bda_qstat_t;

	// Decimal digits of the largest VALUE_BITS-wide number: floor(bits*log10(2)) + 1.
	function automatic int unsigned dec_digits(input int unsigned bits);
		return ((bits * 1233) >> 12) + 1;
	endfunction

	// Double-dabble correction of one BCD digit before the shift.
	function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
		return (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

// ===== design/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII converter. Each input word is an unsigned number whose low
// VALUE_BITS bits are converted; the block returns its decimal form as one output word
// per digit, most significant digit first, with no leading zeros, and marks the units
// digit with last_digit. Zero comes out as a single '0'. Nothing is remembered from
// one number to the next. A front end takes a number and runs a shift-add-3 (double
// dabble) conversion, one bit per cycle, the last bit held while the queue is full;
// after the cycle it is taken in, the number is shifted through bit by bit, and
// in_stall stays high throughout the shifting. The packed BCD result goes into a
// two-entry queue. A back end takes one entry into a register and walks its digit
// positions, one per cycle while the output is not stalled, skipping leading zeros and
// loading each shown digit into an output register. The front end takes a new number
// only after pushing the previous one, and the queue lets it convert while the back
// end still sends earlier digits. When the back end is idle, the first digit word
// passes from the conversion through the queue, the back end's BCD register and the
// output register, and each skipped leading zero delays it further.
module binary_to_decimal_ascii #(
	parameter int unsigned VALUE_BITS = bda_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bda_pkg::INPUT_BITS-1:0] value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bda_pkg::CHAR_BITS-1:0]  digit_char,
	output logic                           last_digit
);
	import bda_pkg::*;

	`include "binary_to_decimal_ascii_macros.svh"

	localparam int unsigned NB = 4 * dec_digits(VALUE_BITS);

	// Handshake and status between the front end, the queue and the back end.
	bda_qstat_t    qstat;
	logic          push;
	logic          pop;
	logic [NB-1:0] push_bcd;
	logic [NB-1:0] pop_bcd;
	logic          digit_ok;

	// The front end converts one number at a time.
	bda_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.qstat    (qstat),
		.push     (push),
		.push_bcd (push_bcd)
	);

	// The queue lets a new conversion run while earlier digits are still being sent.
	bda_queue #(
		.WIDTH(NB)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_bcd),
		.pop       (pop),
		.pop_data  (pop_bcd),
		.qstat     (qstat)
	);

	// The back end turns packed BCD into ASCII digit words.
	bda_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.pop_bcd    (pop_bcd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	assign digit_ok = (digit_char >= ASCII_ZERO) && (digit_char <= 6'd57);

	// The front end must never write a full queue, and the back end never reads an empty one.
	`BDA_ASSERT_NOW(a_no_overflow, push, !qstat.full, "queue written while full")
	`BDA_ASSERT_NOW(a_no_underflow, pop, !qstat.empty, "queue read while empty")
	// A number just taken keeps the front end busy on the next cycle.
	`BDA_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "front end not busy")
	// Every shown digit is an ASCII decimal digit.
	`BDA_ASSERT_NOW(a_digit_range, out_valid, digit_ok, "digit out of range")

endmodule

// ===== design/bda_front.sv =====
module bda_front #(
	parameter int unsigned VALUE_BITS = bda_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  logic [bda_pkg::INPUT_BITS-1:0]             value,
	input  bda_pkg::bda_qstat_t                        qstat,
	output logic                                       push,
	output logic [4*bda_pkg::dec_digits(VALUE_BITS)-1:0] push_bcd
);
	import bda_pkg::*;

	localparam int unsigned NDIG = dec_digits(VALUE_BITS);
	localparam int unsigned NB = 4 * NDIG;
	localparam int unsigned CW = $clog2(VALUE_BITS + 1);
	localparam int unsigned XW = (VALUE_BITS > INPUT_BITS) ? VALUE_BITS : INPUT_BITS;

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [NB-1:0]         bcd_q;
	logic [NB-1:0]         bcd_adj;
	logic [NB-1:0]         bcd_next;
	logic [XW-1:0]         value_wide;
	logic                  final_step;
	logic                  step;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[4*i +: 4] = bcd_adjust(bcd_q[4*i +: 4]);
		end
	end

	assign bcd_next   = {bcd_adj[NB-2:0], bin_q[VALUE_BITS-1]};
	assign value_wide = XW'(value);
	assign final_step = (cnt_q == CW'(1));
	assign step       = busy_q && !(final_step && qstat.full);
	assign push       = busy_q && final_step && !qstat.full;
	assign push_bcd   = bcd_next;
	assign in_stall   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end
		end else if (step) begin
			cnt_q <= cnt_q - CW'(1);
			if (final_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			bin_q <= value_wide[VALUE_BITS-1:0];
			bcd_q <= '0;
		end else if (step) begin
			bin_q <= bin_q << 1;
			bcd_q <= bcd_next;
		end
	end

endmodule

// ===== design/bda_queue.sv =====
module bda_queue #(
	parameter int unsigned WIDTH = 4 * bda_pkg::dec_digits(bda_pkg::DEFAULT_VALUE_BITS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    pop_data,
	output bda_pkg::bda_qstat_t qstat
);
	import bda_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign qstat.empty = (count_q == '0);
	assign qstat.full  = (count_q == NW'(QUEUE_DEPTH));
	assign pop_data    = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : (p + PW'(1));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== design/bda_back.sv =====
module bda_back #(
	parameter int unsigned VALUE_BITS = bda_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  bda_pkg::bda_qstat_t                          qstat,
	input  logic [4*bda_pkg::dec_digits(VALUE_BITS)-1:0] pop_bcd,
	output logic                                         pop,
	output logic                                         out_valid,
	input  logic                                         out_stall,
	output logic [bda_pkg::CHAR_BITS-1:0]                digit_char,
	output logic                                         last_digit
);
	import bda_pkg::*;

	localparam int unsigned NDIG = dec_digits(VALUE_BITS);
	localparam int unsigned NB = 4 * NDIG;
	localparam int unsigned PW = $clog2(NDIG);

	logic                 busy_q;
	logic                 started_q;
	logic [PW-1:0]        pos_q;
	logic [NB-1:0]        bcd_q;
	logic                 out_valid_q;
	logic [CHAR_BITS-1:0] char_q;
	logic                 last_q;
	logic [3:0]           top;
	logic                 out_free;
	logic                 skip;
	logic                 advance;

	assign top       = bcd_q[NB-1 -: 4];
	assign out_free  = !out_valid_q || !out_stall;
	// Leading zeros are dropped, but the units digit is always shown.
	assign skip      = !started_q && (top == 4'd0) && (pos_q != '0);
	assign advance   = busy_q && out_free;
	assign pop       = !busy_q && !qstat.empty;

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			started_q   <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= busy_q && !skip;
			end
			if (pop) begin
				busy_q    <= 1'b1;
				started_q <= 1'b0;
				pos_q     <= PW'(NDIG - 1);
			end else if (advance) begin
				if (!skip) begin
					started_q <= 1'b1;
				end
				if (pos_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q - PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bcd_q <= pop_bcd;
		end else if (advance) begin
			bcd_q <= bcd_q << 4;
		end
		if (advance && !skip) begin
			char_q <= ASCII_ZERO + {2'b00, top};
			last_q <= (pos_q == '0);
		end
	end

endmodule

// ===== sim/binary_to_decimal_ascii_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the converter, builds the expected digit words for every
// accepted number and compares each delivered digit word against the oldest one.
module binary_to_decimal_ascii_checker #(
	parameter int unsigned VALUE_BITS = bda_pkg::DEFAULT_VALUE_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [bda_pkg::INPUT_BITS-1:0] value,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [bda_pkg::CHAR_BITS-1:0]  digit_char,
	input  logic                           last_digit,
	output int unsigned                    mismatch_count,
	output int unsigned                    digits_outstanding
);

	localparam logic [63:0] VALUE_MASK =
		(VALUE_BITS >= 64) ? {64{1'b1}} : ((64'd1 << VALUE_BITS) - 64'd1);
	localparam int unsigned MAX_DIGITS = 20;

	typedef struct packed {
		logic [bda_pkg::CHAR_BITS-1:0] code;
		logic                          units;
	} digit_word_t;

	digit_word_t expected_digits[$];
	digit_word_t oldest;
	int unsigned fail_tally = 0;
	int unsigned backlog = 0;

	assign mismatch_count = fail_tally;
	assign digits_outstanding = backlog;

	// Splits the masked number into decimal digits and queues them most significant first.
	function automatic void queue_decimal_digits(input logic [bda_pkg::INPUT_BITS-1:0] number);
		logic [63:0] rest;
		logic [3:0]  digits[MAX_DIGITS];
		int          count;
		digit_word_t word;
		rest = {{(64 - bda_pkg::INPUT_BITS){1'b0}}, number} & VALUE_MASK;
		count = 0;
		do begin
			digits[count] = 4'(rest % 64'd10);
			rest = rest / 64'd10;
			count++;
		end while (rest != 64'd0 && count < MAX_DIGITS);
		for (int k = count - 1; k >= 0; k--) begin
			word.code = bda_pkg::ASCII_ZERO + {2'b00, digits[k]};
			word.units = (k == 0);
			expected_digits.push_back(word);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_digits.delete();
		end else begin
			if (in_valid && !in_stall)
				queue_decimal_digits(value);
			if (out_valid && !out_stall) begin
				if (expected_digits.size() == 0) begin
					$display("%0t: unexpected digit word, got digit_char %0d last_digit %0d",
						$time, digit_char, last_digit);
					fail_tally++;
				end else begin
					oldest = expected_digits.pop_front();
					if (digit_char !== oldest.code) begin
						$display("%0t: digit_char mismatch, expected %0d, got %0d",
							$time, oldest.code, digit_char);
						fail_tally++;
					end
					if (last_digit !== oldest.units) begin
						$display("%0t: last_digit mismatch, expected %0d, got %0d",
							$time, oldest.units, last_digit);
						fail_tally++;
					end
				end
			end
		end
		backlog = expected_digits.size();
	end

endmodule

// ===== sim/binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

// Top of the converter testbench. It only produces stimulus on the number channel,
// throttles the digit channel, and gives the verdict; all prediction and comparison
// lives in the checker instance next to the block.
module binary_to_decimal_ascii_tb;

	localparam int unsigned RANDOM_WORDS = 87;
	// The final stretch of the run is sent with no idling on either side.
	localparam int unsigned CALM_WORDS = 20;
	// Enough settle time after the last expected digit to catch any stray word.
	localparam int unsigned DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [bda_pkg::INPUT_BITS-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [bda_pkg::CHAR_BITS-1:0] digit_char;
	logic last_digit;

	int unsigned mismatch_count;
	int unsigned digits_outstanding;
	logic calm_tail = 1'b0;

	// Directed numbers: zero, several digit count boundaries, the top of the 32-bit range,
	// zeros buried inside a number, and alternating bit patterns.
	logic [31:0] directed_words[] = '{
		32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101, 32'd1000,
		32'd65535, 32'd65536, 32'd999999999, 32'd1000000000, 32'd1000000007,
		32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd4000000000,
		32'd4294967294, 32'd4294967295, 32'hAAAAAAAA, 32'h55555555, 32'd90909090
	};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	binary_to_decimal_ascii u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

	binary_to_decimal_ascii_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.digit_char         (digit_char),
		.last_digit         (last_digit),
		.mismatch_count     (mismatch_count),
		.digits_outstanding (digits_outstanding)
	);

	// Picks a number with a spread of shapes: fully random bits, a random value of a
	// chosen digit count so short numbers are as common as long ones, a single digit
	// followed by zeros, and tiny values.
	function automatic logic [31:0] pick_number();
		int unsigned shape;
		int unsigned width;
		logic [63:0] low_end;
		logic [63:0] high_end;
		logic [63:0] spread;
		shape = $urandom_range(0, 9);
		if (shape < 4)
			return $urandom;
		if (shape < 8) begin
			width = $urandom_range(1, 10);
			low_end = (width == 1) ? 64'd0 : 64'd1;
			for (int k = 1; k < width; k++)
				low_end = low_end * 64'd10;
			high_end = (width == 1) ? 64'd9 : low_end * 64'd10 - 64'd1;
			if (high_end > 64'hFFFF_FFFF)
				high_end = 64'hFFFF_FFFF;
			spread = {$urandom, $urandom} % (high_end - low_end + 64'd1);
			return 32'(low_end + spread);
		end
		if (shape == 8) begin
			high_end = 64'($urandom_range(1, 9));
			width = $urandom_range(0, 9);
			for (int k = 0; k < width; k++)
				high_end = high_end * 64'd10;
			if (high_end > 64'hFFFF_FFFF)
				high_end = 64'd1000000000;
			return 32'(high_end);
		end
		return $urandom_range(0, 20);
	endfunction

	// Called at a falling edge. Holds the number steady until the block takes it and
	// returns at the falling edge after the handshake.
	task automatic send_word(input logic [31:0] number);
		in_valid <= 1'b1;
		value <= number;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Sometimes drops valid for a short burst before the next word.
	task automatic maybe_pause_sender();
		int unsigned gap;
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Lets the block catch up completely before more numbers are offered.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (digits_outstanding != 0)
			@(negedge clk);
	endtask

	// Digit side back-pressure: stall bursts of random length, none at the end.
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 4);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_words[i]) begin
			maybe_pause_sender();
			send_word(directed_words[i]);
		end

		// Let every digit of the directed numbers come out before random traffic starts.
		wait_for_drain();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n == RANDOM_WORDS / 2)
				wait_for_drain();
			if (n == RANDOM_WORDS - CALM_WORDS)
				calm_tail = 1'b1;
			maybe_pause_sender();
			send_word(pick_number());
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatch_count == 0 && digits_outstanding == 0)
			$display("binary_to_decimal_ascii test passed");
		else
			$display("binary_to_decimal_ascii test failed");
		$finish;
	end

	// A correct run needs well under a tenth of this time.
	initial begin
		#1ms;
		$display("binary_to_decimal_ascii test failed");
		$finish;
	end

endmodule
